### rtl/mbrf_pkg.sv
// package for the modbus read request framer: types, constants and crc helpers
package mbrf_pkg;

    // frame constants
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  COUNT_HIGH_BYTE   = 8'h00;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [9:0]  REPLY_BASE        = 10'd5;

    // byte positions within one frame, in transmission order
    localparam logic [2:0] BYTE_SLAVE    = 3'd0;
    localparam logic [2:0] BYTE_FUNC     = 3'd1;
    localparam logic [2:0] BYTE_START_HI = 3'd2;
    localparam logic [2:0] BYTE_START_LO = 3'd3;
    localparam logic [2:0] BYTE_COUNT_HI = 3'd4;
    localparam logic [2:0] BYTE_COUNT_LO = 3'd5;
    localparam logic [2:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [2:0] BYTE_CRC_HI   = 3'd7;

    // request payload
    typedef struct packed {
        logic [7:0]  slave_id;
        logic [15:0] start_register;
        logic [7:0]  register_count;
    } req_t;

    // result payload, one per frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [9:0] reply_length;
    } rsp_t;

    // finished frame handed from the builder to the serializer
    typedef struct packed {
        logic [7:0]  slave_id;
        logic [15:0] start_register;
        logic [7:0]  register_count;
        logic [15:0] crc;
        logic [9:0]  reply_length;
    } frame_t;

    // byte-wise crc table entry for the reflected polynomial
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // fold one byte into the running crc
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] idx;
        idx = crc[7:0] ^ data;
        return {8'h00, crc[15:8]} ^ crc_table(idx);
    endfunction

endpackage

### rtl/mbrf_frame_builder.sv
// request register and two-stage crc pipeline that builds one frame per request
module mbrf_frame_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mbrf_pkg::req_t       req,
    output logic                 frame_valid,
    input  logic                 frame_ready,
    output mbrf_pkg::frame_t     frame
);

    logic               v0_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v0_next;
    logic               v1_next;
    logic               v2_next;
    logic               r0;
    logic               r1;
    logic               r2;
    mbrf_pkg::req_t     req0_reg;
    mbrf_pkg::req_t     req1_reg;
    logic [15:0]        crc1_reg;
    logic [9:0]         reply1_reg;
    mbrf_pkg::frame_t   frame2_reg;
    logic [15:0]        crc1_next;
    logic [15:0]        crc2_next;
    logic [9:0]         reply1_next;

    // each stage loads when empty or when its contents move on
    assign r2        = !v2_reg || frame_ready;
    assign r1        = !v1_reg || r2;
    assign r0        = !v0_reg || r1;
    assign req_ready = r0;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (r0)
            v0_next = req_valid;
        if (r1)
            v1_next = v0_reg;
        if (r2)
            v2_next = v1_reg;
    end

    // crc over slave address, function code and start high byte, and the expected reply length
    always_comb
    begin
        crc1_next = mbrf_pkg::crc_update(mbrf_pkg::CRC_INIT, req0_reg.slave_id);
        crc1_next = mbrf_pkg::crc_update(crc1_next, mbrf_pkg::FUNC_READ_HOLDING);
        crc1_next = mbrf_pkg::crc_update(crc1_next, req0_reg.start_register[15:8]);
        reply1_next = mbrf_pkg::REPLY_BASE + {1'b0, req0_reg.register_count, 1'b0};
    end

    // crc over start low byte, count high byte and count
    always_comb
    begin
        crc2_next = mbrf_pkg::crc_update(crc1_reg, req1_reg.start_register[7:0]);
        crc2_next = mbrf_pkg::crc_update(crc2_next, mbrf_pkg::COUNT_HIGH_BYTE);
        crc2_next = mbrf_pkg::crc_update(crc2_next, req1_reg.register_count);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (r0 && req_valid)
            req0_reg <= req;
        if (r1 && v0_reg)
        begin
            req1_reg   <= req0_reg;
            crc1_reg   <= crc1_next;
            reply1_reg <= reply1_next;
        end
        if (r2 && v1_reg)
        begin
            frame2_reg.slave_id       <= req1_reg.slave_id;
            frame2_reg.start_register <= req1_reg.start_register;
            frame2_reg.register_count <= req1_reg.register_count;
            frame2_reg.crc            <= crc2_next;
            frame2_reg.reply_length   <= reply1_reg;
        end
    end

    assign frame_valid = v2_reg;
    assign frame       = frame2_reg;

endmodule

### rtl/mbrf_serializer.sv
// frame register and byte counter that send a frame one byte per transaction
module mbrf_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    output logic                 frame_ready,
    input  mbrf_pkg::frame_t     frame,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mbrf_pkg::rsp_t       rsp
);

    logic               busy_reg;
    logic               busy_next;
    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    mbrf_pkg::frame_t   frame_reg;
    logic               at_last;
    logic [7:0]         byte_sel;

    assign at_last     = (idx_reg == mbrf_pkg::BYTE_CRC_HI);
    // next frame loads as the last byte of the current one leaves
    assign frame_ready = !busy_reg || (rsp_ready && at_last);

    // byte counter
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (frame_valid && frame_ready)
        begin
            busy_next = 1'b1;
            idx_next  = mbrf_pkg::BYTE_SLAVE;
        end
        else if (busy_reg && rsp_ready)
        begin
            if (at_last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= mbrf_pkg::BYTE_SLAVE;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
            frame_reg <= frame;
    end

    // byte select in transmission order
    always_comb
    begin
        case (idx_reg)
            mbrf_pkg::BYTE_SLAVE:    byte_sel = frame_reg.slave_id;
            mbrf_pkg::BYTE_FUNC:     byte_sel = mbrf_pkg::FUNC_READ_HOLDING;
            mbrf_pkg::BYTE_START_HI: byte_sel = frame_reg.start_register[15:8];
            mbrf_pkg::BYTE_START_LO: byte_sel = frame_reg.start_register[7:0];
            mbrf_pkg::BYTE_COUNT_HI: byte_sel = mbrf_pkg::COUNT_HIGH_BYTE;
            mbrf_pkg::BYTE_COUNT_LO: byte_sel = frame_reg.register_count;
            mbrf_pkg::BYTE_CRC_LO:   byte_sel = frame_reg.crc[7:0];
            mbrf_pkg::BYTE_CRC_HI:   byte_sel = frame_reg.crc[15:8];
            default:                 byte_sel = frame_reg.slave_id;
        endcase
    end

    assign rsp_valid         = busy_reg;
    assign rsp.frame_byte    = byte_sel;
    assign rsp.last_byte     = at_last;
    assign rsp.reply_length  = frame_reg.reply_length;

endmodule

### rtl/modbus_read_request_framer_top.sv
// top level of the modbus rtu read-holding-registers request framer
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | mbrf_pkg::req_t (one read request)
//  rsp     | out       | rsp_valid/rsp_ready  | mbrf_pkg::rsp_t (one frame byte)
//
// each request yields eight byte transactions, one per cycle while rsp_ready is high;
// the byte counter in the serializer sets the rate: it loads a new frame as the last byte leaves.
// a request passes the input register, the two crc stages and the serializer frame register.
// reset clears only valid bits and the byte counter; no clearing pass is needed.
// a stalled output holds its byte; the three-deep pipeline keeps taking requests until full.
module modbus_read_request_framer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mbrf_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mbrf_pkg::rsp_t       rsp
);

    logic               frame_valid;
    logic               frame_ready;
    mbrf_pkg::frame_t   frame;

    // request register and crc pipeline
    mbrf_frame_builder u_builder (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // byte serializer
    mbrf_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

`ifndef SYNTH
    // a frame keeps going until its last byte has been taken
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !rsp.last_byte) |=> rsp_valid)
        else $error("frame stopped before its last byte");

    // expected reply length is always odd and at least five
    a_reply_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.reply_length[0] && rsp.reply_length >= mbrf_pkg::REPLY_BASE))
        else $error("reply length out of range");

    // the serializer only refuses a frame while it is sending one
    a_serializer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_ready) |-> rsp_valid)
        else $error("serializer idle but refused a frame");
`endif

endmodule
